// ----- src/bpa_pkg.sv -----
// shared types, constants and codes of the bitmap page allocator
`default_nettype none
package bpa_pkg;

  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  localparam int DEF_MAX_PAGES  = 1024;
  localparam int DEF_PAGE_BYTES = 4096;

  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 11;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [LEN_W-1:0] REGION_PAGES_RESET = 11'd1024;

  // request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_PAGES = 2'd1;

  // run scanner result for one bitmap word
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
  } bpa_hit_t;

endpackage
`default_nettype wire

// ----- src/bpa_bitmap_ram.sv -----
// bitmap word memory, one write port and one registered read port
`default_nettype none
module bpa_bitmap_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [bpa_pkg::WORD_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic      [bpa_pkg::WORD_W-1:0] rdata
);

  logic [bpa_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/bpa_run_scan.sv -----
// free run scanner: extends a run of free pages across one bitmap word
`default_nettype none
module bpa_run_scan #(
  parameter int CNT_W = 11
) (
  input  wire logic [bpa_pkg::WORD_W-1:0] word_i,
  input  wire logic [CNT_W-1:0]           run_in,
  input  wire logic [CNT_W-1:0]           len_i,
  output bpa_pkg::bpa_hit_t               hit_o,
  output logic      [CNT_W-1:0]           run_out
);

  logic [CNT_W:0]                 run_j [bpa_pkg::WORD_W];
  logic [bpa_pkg::WORD_W-1:0]     hit_v;
  logic [bpa_pkg::BIT_W-1:0]      last_used;
  logic                           seen;

  // run ending at bit j: distance to the last used bit at or below j,
  // or the incoming run plus j+1 when the word is free up to j
  always_comb begin
    last_used = '0;
    seen      = 1'b0;
    for (int j = 0; j < bpa_pkg::WORD_W; j++) begin
      last_used = '0;
      seen      = 1'b0;
      for (int k = 0; k <= j; k++) begin
        if (word_i[k]) begin
          last_used = bpa_pkg::BIT_W'(k);
          seen      = 1'b1;
        end
      end
      if (seen) begin
        run_j[j] = (CNT_W+1)'(j) - (CNT_W+1)'(last_used);
      end else begin
        run_j[j] = (CNT_W+1)'(run_in) + (CNT_W+1)'(j + 1);
      end
      hit_v[j] = (run_j[j] >= {1'b0, len_i});
    end
  end

  // lowest bit that completes the run
  always_comb begin
    hit_o.hit = |hit_v;
    hit_o.pos = '0;
    for (int j = bpa_pkg::WORD_W - 1; j >= 0; j--) begin
      if (hit_v[j]) begin
        hit_o.pos = bpa_pkg::BIT_W'(j);
      end
    end
  end

  assign run_out = run_j[bpa_pkg::WORD_W-1][CNT_W-1:0];

endmodule
`default_nettype wire

// ----- src/bitmap_page_allocator_unit.sv -----
// top level of the first-fit bitmap page allocator
//
// usage
//   requests come in on start/in_* and are taken at an edge where start is
//   high and busy is low. in_action selects allocate or free. each request
//   gives one result on out_page_address/out_status, shown for exactly one
//   cycle with out_valid high; the receiver cannot hold it off.
//   cfg_valid/cfg_ready/cfg_index/cfg_data writes region_start (index 0)
//   and region_pages (index 1); cfg_ready is always high, write only idle.
// timing
//   the used-page bitmap sits in a word memory, 32 pages per word. one
//   shared run scanner looks at one word per cycle, and the marking pass
//   rewrites one word per cycle. allocate scans words until a run fits and
//   then marks the words of the run; free marks only the words it touches.
// reset
//   rst_n clears the control state and then a clearing pass writes zero
//   into every bitmap word, one word a cycle; busy stays high during that pass.
`default_nettype none
module bitmap_page_allocator_unit #(
  parameter int MAX_PAGES  = bpa_pkg::DEF_MAX_PAGES,
  parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_action,
  input  wire logic [bpa_pkg::LEN_W-1:0]       in_run_length,
  input  wire logic [bpa_pkg::ADDR_W-1:0]      in_free_address,
  // result channel
  output logic                                 out_valid,
  output logic      [bpa_pkg::ADDR_W-1:0]      out_page_address,
  output logic      [bpa_pkg::STATUS_W-1:0]    out_status,
  // configuration channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // page size is a power of two, so page index is a plain shift
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PCNT_W     = $clog2(MAX_PAGES + 1);
  localparam int CNT_W      = (PCNT_W > bpa_pkg::LEN_W) ? PCNT_W : bpa_pkg::LEN_W;
  localparam int NWORDS     = (MAX_PAGES + bpa_pkg::WORD_W - 1) / bpa_pkg::WORD_W;
  localparam int WADDR_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int IDXF_W     = bpa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int SUM_W      = bpa_pkg::ADDR_W + 2;
  localparam int BW         = bpa_pkg::BIT_W;

  typedef enum logic [9:0] {
    S_CLEAR      = 10'b00_0000_0001,
    S_IDLE       = 10'b00_0000_0010,
    S_FREE_SUB   = 10'b00_0000_0100,
    S_FREE_CHK   = 10'b00_0000_1000,
    S_SCAN_START = 10'b00_0001_0000,
    S_SCAN       = 10'b00_0010_0000,
    S_SCAN_END   = 10'b00_0100_0000,
    S_MARK_START = 10'b00_1000_0000,
    S_MARK       = 10'b01_0000_0000,
    S_DONE_WAIT  = 10'b10_0000_0000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [WADDR_W-1:0]               clr_w_r, clr_w_nxt;
  logic [bpa_pkg::ADDR_W-1:0]       region_start_r;
  logic [bpa_pkg::LEN_W-1:0]        region_pages_r;

  // latched request
  logic                             action_r, action_nxt;
  logic [bpa_pkg::LEN_W-1:0]        len_r, len_nxt;
  logic [bpa_pkg::ADDR_W-1:0]       faddr_r, faddr_nxt;

  // free range check
  logic                             ge_r, ge_nxt;
  logic [IDXF_W-1:0]                idx_r, idx_nxt;

  // scan and mark
  logic [WADDR_W-1:0]               scan_w_r, scan_w_nxt;
  logic [CNT_W-1:0]                 run_r, run_nxt;
  logic [CNT_W-1:0]                 end_r, end_nxt;
  logic [CNT_W-1:0]                 lo_r, lo_nxt;
  logic [CNT_W-1:0]                 hi_r, hi_nxt;
  logic [WADDR_W-1:0]               mark_w_r, mark_w_nxt;

  // result register
  logic                             out_valid_r, out_valid_nxt;
  logic [bpa_pkg::ADDR_W-1:0]       out_addr_r, out_addr_nxt;
  logic [bpa_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;

  // memory port
  logic                             mem_we;
  logic [WADDR_W-1:0]               mem_waddr;
  logic [bpa_pkg::WORD_W-1:0]       mem_wdata;
  logic [WADDR_W-1:0]               mem_raddr;
  logic [bpa_pkg::WORD_W-1:0]       mem_rdata;

  // derived values
  logic [CNT_W-1:0]                 pages;
  logic [CNT_W-1:0]                 pages_m1;
  logic [WADDR_W-1:0]               last_w;
  logic [BW-1:0]                    tail_b;
  logic [bpa_pkg::WORD_W-1:0]       tail_mask;
  logic [bpa_pkg::WORD_W-1:0]       scan_word;
  logic [CNT_W-1:0]                 len_w;
  logic [WADDR_W-1:0]               lo_w, hi_w;
  logic [bpa_pkg::WORD_W-1:0]       lo_mask, hi_mask, run_mask;
  logic [SUM_W-1:0]                 free_end;
  logic [bpa_pkg::ADDR_W-1:0]       alloc_addr;
  bpa_pkg::bpa_hit_t                scan_hit;
  logic [CNT_W-1:0]                 scan_run;

  // pages in use: region_pages clipped to the bitmap size
  always_comb begin
    if (CNT_W'(region_pages_r) > CNT_W'(MAX_PAGES)) begin
      pages = CNT_W'(MAX_PAGES);
    end else begin
      pages = CNT_W'(region_pages_r);
    end
  end

  assign pages_m1 = pages - CNT_W'(1);
  assign last_w   = pages_m1[WADDR_W+BW-1:BW];
  assign tail_b   = pages[BW-1:0];
  assign len_w    = CNT_W'(len_r);

  // pages past the region in the last word count as used for the scan
  always_comb begin
    if ((scan_w_r == last_w) && (tail_b != '0)) begin
      tail_mask = {bpa_pkg::WORD_W{1'b1}} << tail_b;
    end else begin
      tail_mask = '0;
    end
  end

  assign scan_word = mem_rdata | tail_mask;

  // bits of the current word that lie inside the run lo..hi
  assign lo_w = lo_r[WADDR_W+BW-1:BW];
  assign hi_w = hi_r[WADDR_W+BW-1:BW];

  always_comb begin
    if (mark_w_r == lo_w) begin
      lo_mask = {bpa_pkg::WORD_W{1'b1}} << lo_r[BW-1:0];
    end else begin
      lo_mask = {bpa_pkg::WORD_W{1'b1}};
    end
    if (mark_w_r == hi_w) begin
      hi_mask = {bpa_pkg::WORD_W{1'b1}} >> (BW'(bpa_pkg::WORD_W - 1) - hi_r[BW-1:0]);
    end else begin
      hi_mask = {bpa_pkg::WORD_W{1'b1}};
    end
    run_mask = lo_mask & hi_mask;
  end

  assign free_end   = SUM_W'(idx_r) + SUM_W'(len_r);
  assign alloc_addr = region_start_r + (bpa_pkg::ADDR_W'(lo_r) << PAGE_SHIFT);

  bpa_run_scan #(
    .CNT_W (CNT_W)
  ) u_scan (
    .word_i  (scan_word),
    .run_in  (run_r),
    .len_i   (len_w),
    .hit_o   (scan_hit),
    .run_out (scan_run)
  );

  bpa_bitmap_ram #(
    .DEPTH (NWORDS),
    .AW    (WADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_w_nxt      = clr_w_r;
    action_nxt     = action_r;
    len_nxt        = len_r;
    faddr_nxt      = faddr_r;
    ge_nxt         = ge_r;
    idx_nxt        = idx_r;
    scan_w_nxt     = scan_w_r;
    run_nxt        = run_r;
    end_nxt        = end_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mark_w_nxt     = mark_w_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_w_r;
    mem_wdata      = '0;
    mem_raddr      = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_w_r;
        mem_wdata = '0;
        if (clr_w_r == WADDR_W'(NWORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_w_nxt = clr_w_r + WADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          action_nxt = in_action;
          len_nxt    = in_run_length;
          faddr_nxt  = in_free_address;
          if (in_action == bpa_pkg::ACT_FREE) begin
            state_nxt = S_FREE_SUB;
          end else if ((in_run_length == '0) || (pages == '0)) begin
            // empty request or empty region: no run can be found
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_status_nxt = bpa_pkg::ST_NOSPACE;
          end else begin
            state_nxt = S_SCAN_START;
          end
        end
      end

      S_FREE_SUB: begin
        ge_nxt    = (faddr_r >= region_start_r);
        idx_nxt   = IDXF_W'((faddr_r - region_start_r) >> PAGE_SHIFT);
        state_nxt = S_FREE_CHK;
      end

      S_FREE_CHK: begin
        if (!ge_r || (free_end > SUM_W'(pages))) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = bpa_pkg::ST_OUTSIDE;
          state_nxt      = S_IDLE;
        end else if (len_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = bpa_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          lo_nxt    = CNT_W'(idx_r);
          hi_nxt    = CNT_W'(free_end - SUM_W'(1));
          state_nxt = S_MARK_START;
        end
      end

      S_SCAN_START: begin
        mem_raddr  = '0;
        scan_w_nxt = '0;
        run_nxt    = '0;
        state_nxt  = S_SCAN;
      end

      S_SCAN: begin
        // read of the next word overlaps the check of this one
        mem_raddr = scan_w_r + WADDR_W'(1);
        if (scan_hit.hit) begin
          end_nxt   = CNT_W'({scan_w_r, scan_hit.pos});
          state_nxt = S_SCAN_END;
        end else if (scan_w_r == last_w) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = bpa_pkg::ST_NOSPACE;
          state_nxt      = S_IDLE;
        end else begin
          scan_w_nxt = scan_w_r + WADDR_W'(1);
          run_nxt    = scan_run;
        end
      end

      S_SCAN_END: begin
        lo_nxt    = end_r + CNT_W'(1) - len_w;
        hi_nxt    = end_r;
        state_nxt = S_MARK_START;
      end

      S_MARK_START: begin
        mem_raddr  = lo_w;
        mark_w_nxt = lo_w;
        state_nxt  = S_MARK;
      end

      S_MARK: begin
        // read-modify-write, one word a cycle
        mem_we    = 1'b1;
        mem_waddr = mark_w_r;
        if (action_r == bpa_pkg::ACT_FREE) begin
          mem_wdata = mem_rdata & ~run_mask;
        end else begin
          mem_wdata = mem_rdata | run_mask;
        end
        mem_raddr = mark_w_r + WADDR_W'(1);
        if (mark_w_r == hi_w) begin
          state_nxt = S_DONE_WAIT;
        end else begin
          mark_w_nxt = mark_w_r + WADDR_W'(1);
        end
      end

      S_DONE_WAIT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = bpa_pkg::ST_OK;
        if (action_r == bpa_pkg::ACT_FREE) begin
          out_addr_nxt = '0;
        end else begin
          out_addr_nxt = alloc_addr;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_w_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_w_r     <= clr_w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_pages_r <= bpa_pkg::REGION_PAGES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpa_pkg::REG_REGION_START: begin
          region_start_r <= cfg_data;
        end
        bpa_pkg::REG_REGION_PAGES: begin
          region_pages_r <= cfg_data[bpa_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    len_r        <= len_nxt;
    faddr_r      <= faddr_nxt;
    ge_r         <= ge_nxt;
    idx_r        <= idx_nxt;
    scan_w_r     <= scan_w_nxt;
    run_r        <= run_nxt;
    end_r        <= end_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mark_w_r     <= mark_w_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_page_address = out_addr_r;
  assign out_status       = out_status_r;

endmodule
`default_nettype wire

// ----- verif/page_map_checker.sv -----
// request/result checker for the bitmap page allocator, with its own page map
module page_map_checker
  import bpa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic                  in_action,
  input  wire logic [LEN_W-1:0]      in_run_length,
  input  wire logic [ADDR_W-1:0]     in_free_address,
  input  wire logic                  out_valid,
  input  wire logic [ADDR_W-1:0]     out_page_address,
  input  wire logic [STATUS_W-1:0]   out_status,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         mismatch_cnt,
  output int                         awaiting,
  output int                         ok_cnt,
  output int                         nospace_cnt,
  output int                         outside_cnt
);

  localparam int MAX_PG     = DEF_MAX_PAGES;
  localparam int PAGE_BYTES = DEF_PAGE_BYTES;
  localparam int PRINT_CAP  = 40;

  typedef struct {
    logic [ADDR_W-1:0]   page_address;
    logic [STATUS_W-1:0] status;
  } grant_t;

  logic              page_used [MAX_PG];
  logic [ADDR_W-1:0] base_addr;
  logic [LEN_W-1:0]  page_limit;
  grant_t            grant_q [$];
  grant_t            fresh;
  grant_t            oldest;

  task automatic note_mismatch(input string msg);
    if (mismatch_cnt < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // first-fit claim or release on the local page map
  function automatic grant_t claim_or_release(input logic act, input logic [LEN_W-1:0] len,
                                              input logic [ADDR_W-1:0] fa);
    grant_t            g;
    int unsigned       npages, run, first, idx;
    logic [ADDR_W-1:0] offset;
    bit                found;
    npages = (page_limit > MAX_PG) ? MAX_PG : page_limit;
    g.page_address = '0;
    found = 1'b0;
    run = 0;
    first = 0;
    if (act == ACT_ALLOC) begin
      g.status = ST_NOSPACE;
      if (len != 0) begin
        for (int unsigned i = 0; i < npages && !found; i++) begin
          if (page_used[i]) begin
            run = 0;
          end else begin
            run++;
            if (run == len) begin
              first = i + 1 - len;
              found = 1'b1;
            end
          end
        end
      end
      if (found) begin
        for (int unsigned i = first; i < first + len; i++) page_used[i] = 1'b1;
        g.page_address = base_addr + ADDR_W'(first * PAGE_BYTES);
        g.status = ST_OK;
      end
    end else begin
      g.status = ST_OUTSIDE;
      if (fa >= base_addr) begin
        offset = fa - base_addr;
        idx = offset / PAGE_BYTES;
        if (idx + len <= npages) begin
          for (int unsigned i = idx; i < idx + len; i++) page_used[i] = 1'b0;
          g.status = ST_OK;
        end
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (page_used[i]) page_used[i] = 1'b0;
      base_addr = '0;
      page_limit = REGION_PAGES_RESET;
      grant_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REGION_START: base_addr = cfg_data;
          REG_REGION_PAGES: page_limit = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        fresh = claim_or_release(in_action, in_run_length, in_free_address);
        grant_q.push_back(fresh);
        case (fresh.status)
          ST_OK:      ok_cnt++;
          ST_NOSPACE: nospace_cnt++;
          default:    outside_cnt++;
        endcase
      end
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          note_mismatch($sformatf("result 0x%08h/%0d with no request waiting",
                                  out_page_address, out_status));
        end else begin
          oldest = grant_q.pop_front();
          if (out_page_address !== oldest.page_address)
            note_mismatch($sformatf("page_address got 0x%08h want 0x%08h",
                                    out_page_address, oldest.page_address));
          if (out_status !== oldest.status)
            note_mismatch($sformatf("status got %0d want %0d", out_status, oldest.status));
        end
      end
    end
    awaiting <= grant_q.size();
  end

endmodule

// ----- verif/tb.sv -----
// testbench top for the bitmap page allocator: stimulus, region settings and verdict
module tb;
  import bpa_pkg::*;

  localparam int MAX_PG      = DEF_MAX_PAGES;
  localparam int PAGE_BYTES  = DEF_PAGE_BYTES;
  localparam int CYCLE_LIMIT = 1_000_000;
  // longer than the slowest allocate (full scan plus marking)
  localparam int SETTLE      = 80;
  // register index that maps to nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // every input known from time zero
  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  start           = 1'b0;
  logic                  in_action       = ACT_ALLOC;
  logic [LEN_W-1:0]      in_run_length   = '0;
  logic [ADDR_W-1:0]     in_free_address = '0;
  logic                  cfg_valid       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = REG_REGION_START;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  logic                  busy;
  logic                  out_valid;
  logic [ADDR_W-1:0]     out_page_address;
  logic [STATUS_W-1:0]   out_status;
  logic                  cfg_ready;

  int mismatch_cnt, awaiting, ok_cnt, nospace_cnt, outside_cnt;
  int sent_cnt, setting_cnt, drain_cnt, cycle_cnt;

  // region as last written, used to aim frees inside it
  logic [ADDR_W-1:0] cur_base  = '0;
  logic [LEN_W-1:0]  cur_pages = REGION_PAGES_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_page_allocator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_run_length    (in_run_length),
    .in_free_address  (in_free_address),
    .out_valid        (out_valid),
    .out_page_address (out_page_address),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  page_map_checker map_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_run_length    (in_run_length),
    .in_free_address  (in_free_address),
    .out_valid        (out_valid),
    .out_page_address (out_page_address),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_cnt     (mismatch_cnt),
    .awaiting         (awaiting),
    .ok_cnt           (ok_cnt),
    .nospace_cnt      (nospace_cnt),
    .outside_cnt      (outside_cnt)
  );

  // present one request and hold it until the block takes it
  // start stays high on return so the next request can follow back to back
  task automatic issue(input logic act, input int unsigned len, input logic [ADDR_W-1:0] fa);
    start <= 1'b1;
    in_action <= act;
    in_run_length <= LEN_W'(len);
    in_free_address <= fa;
    do @(posedge clk); while (busy !== 1'b0);
    sent_cnt++;
  endtask

  // gap between bursts, with junk on the fields while start is low
  task automatic pause(input int n);
    start <= 1'b0;
    in_action <= 1'($urandom);
    in_run_length <= LEN_W'($urandom);
    in_free_address <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  // stop sending until every outstanding request has its result
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (SETTLE) @(posedge clk);
    drain_cnt++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_REGION_START) cur_base = data;
    else if (idx == REG_REGION_PAGES) cur_pages = data[LEN_W-1:0];
  endtask

  // new region; only called with the block idle
  task automatic retarget(input logic [ADDR_W-1:0] base, input logic [CFG_DATA_W-1:0] pages);
    write_reg(REG_REGION_START, base);
    write_reg(REG_REGION_PAGES, pages);
    setting_cnt++;
  endtask

  // mostly allocates and frees that land inside the region, some raw noise
  task automatic pick_request(output logic act, output logic [LEN_W-1:0] len,
                              output logic [ADDR_W-1:0] fa);
    int unsigned roll, sub, active, idx, room;
    roll = $urandom_range(0, 99);
    sub = $urandom_range(0, 99);
    active = (cur_pages > MAX_PG) ? MAX_PG : cur_pages;
    fa = $urandom;
    if (roll < 52) begin
      act = ACT_ALLOC;
      // small runs dominate so the map fragments; a few huge or illegal lengths
      if (sub < 80) len = LEN_W'($urandom_range(1, 16));
      else if (sub < 93) len = LEN_W'($urandom_range(17, 200));
      else if (sub < 97) len = LEN_W'($urandom_range(201, 1024));
      else if (sub < 98) len = '0;
      else len = LEN_W'($urandom_range(1025, 2047));
    end else if (roll < 90) begin
      act = ACT_FREE;
      if (active == 0) begin
        idx = 0;
        len = '0;
      end else begin
        idx = $urandom_range(0, active - 1);
        room = active - idx;
        if (sub < 10) len = LEN_W'($urandom_range(0, room));
        else len = LEN_W'($urandom_range(1, (room < 32) ? room : 32));
      end
      // any byte inside the first page of the run
      fa = cur_base + ADDR_W'(idx * PAGE_BYTES) + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
    end else begin
      act = 1'($urandom);
      len = LEN_W'($urandom);
    end
  endtask

  // bursts of random length, gaps of random length, now and then a full drain
  task automatic random_phase(input int n);
    int                left, burst;
    logic              act;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] fa;
    left = n;
    while (left > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 5);
      for (int k = 0; k < burst && left > 0; k++) begin
        pick_request(act, len, fa);
        issue(act, len, fa);
        left--;
      end
      if ($urandom_range(0, 39) == 0) drain();
      else pause(($urandom_range(0, 5) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12));
    end
  endtask

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, awaiting);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset region: base 0, 1024 pages, all free
    issue(ACT_ALLOC, 0, '0);                  // zero-length allocate gets no-space
    issue(ACT_ALLOC, 1, '0);                  // page 0
    issue(ACT_ALLOC, 1024, '0);               // does not fit around page 0
    issue(ACT_FREE, 1, 32'h0000_0000);
    issue(ACT_ALLOC, 1024, 32'hFFFF_FFFF);    // whole region
    issue(ACT_ALLOC, 1, '0);                  // map full
    issue(ACT_FREE, 0, 32'h0000_1234);        // zero-length, unaligned, inside
    issue(ACT_FREE, 24, 32'h003E_8005);       // unaligned, ends exactly at the top
    issue(ACT_FREE, 25, 32'h003E_8000);       // one page past the top
    issue(ACT_FREE, 2047, 32'hFFFF_FFFF);     // far outside, longest length
    issue(ACT_ALLOC, 2047, '0);               // longer than any region
    issue(ACT_ALLOC, 24, '0);                 // refills the top 24 pages
    issue(ACT_FREE, 1023, 32'h0000_0FFF);     // last byte of page 0
    issue(ACT_ALLOC, 1023, '0);
    issue(ACT_FREE, 1024, 32'h0000_0000);
    issue(ACT_FREE, 1024, 32'h0000_0000);     // freeing pages already free
    drain();
    random_phase(240);
    drain();

    // region near the top of the address space: grants wrap through zero
    retarget(32'hFFFF_F000, 32'd1024);
    issue(ACT_ALLOC, 1, '0);
    issue(ACT_ALLOC, 1, '0);                  // ok at address 0
    issue(ACT_FREE, 1, 32'h0000_0000);        // below the base
    issue(ACT_FREE, 2, 32'hFFFF_F800);
    issue(ACT_ALLOC, 2, '0);
    drain();
    random_phase(200);
    drain();

    // shrink to a small region; pages above it keep their bits
    retarget({20'($urandom), 12'h000}, 32'd40);
    random_phase(200);
    drain();

    // empty region, stray bits above the page count field, unmapped index
    retarget(32'h8000_0000, {21'($urandom), 11'd0});
    write_reg(REG_UNUSED, $urandom);
    random_phase(40);
    drain();

    // unaligned base and a page count past the map size
    retarget($urandom, 32'd2047);
    random_phase(200);
    drain();

    // single page at the very last address
    retarget(32'hFFFF_FFFF, 32'd1);
    random_phase(60);
    drain();

    retarget(32'h0000_0000, {21'($urandom), 11'd700});
    random_phase(260);
    drain();

    $display("run: %0d requests over %0d region settings (ok %0d, no free run %0d, outside %0d)",
             sent_cnt, setting_cnt + 1, ok_cnt, nospace_cnt, outside_cnt);
    $display("run: %0d pauses for all results, %0d cycles", drain_cnt, cycle_cnt);
    if (mismatch_cnt == 0 && awaiting == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
